[rtl/idll_pkg.sv]
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types, codes and the control store of the indexed linked list.
// ----------------------------------------------------------------------------
`default_nettype none

package idll_pkg;

  localparam int unsigned MAX_IDS_DEF = 1024;

  localparam int unsigned ID_W   = 11;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned UPC_W  = 4;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HIDE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd3;

  // control store addresses
  localparam logic [UPC_W-1:0] UA_FETCH = 4'd0;
  localparam logic [UPC_W-1:0] UA_DISP  = 4'd1;
  localparam logic [UPC_W-1:0] UA_ERR   = 4'd2;
  localparam logic [UPC_W-1:0] UA_HIDE  = 4'd3;
  localparam logic [UPC_W-1:0] UA_RD0   = 4'd4;
  localparam logic [UPC_W-1:0] UA_RD1   = 4'd5;
  localparam logic [UPC_W-1:0] UA_INS0  = 4'd6;
  localparam logic [UPC_W-1:0] UA_INS1  = 4'd7;
  localparam logic [UPC_W-1:0] UA_INS2  = 4'd8;

  typedef enum logic [2:0] {
    MO_NONE,
    MO_RD_CUR,
    MO_RD_NBR,
    MO_WR_HIDE,
    MO_WR_NEW,
    MO_WR_LINK
  } mem_op_e;

  typedef enum logic [2:0] {
    RS_NONE,
    RS_ERR,
    RS_HIDE,
    RS_READ,
    RS_INS
  } res_sel_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_FETCH,
    J_WAIT,
    J_CLASS
  } jmp_e;

  typedef enum logic [2:0] {
    CL_RANGE,
    CL_ABSENT,
    CL_FULL,
    CL_READ,
    CL_HIDE,
    CL_INSERT
  } req_cls_e;

  typedef struct packed {
    mem_op_e  op;
    res_sel_e res;
    jmp_e     jmp;
  } ctrl_word_t;

  typedef struct packed {
    req_cls_e cls;
    logic     go;
  } dp_stat_t;

  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_word_t w;
    w = '{op: MO_NONE, res: RS_NONE, jmp: J_FETCH};
    unique case (upc)
      UA_FETCH: w = '{op: MO_NONE,    res: RS_NONE, jmp: J_WAIT};
      UA_DISP:  w = '{op: MO_NONE,    res: RS_NONE, jmp: J_CLASS};
      UA_ERR:   w = '{op: MO_NONE,    res: RS_ERR,  jmp: J_FETCH};
      UA_HIDE:  w = '{op: MO_WR_HIDE, res: RS_HIDE, jmp: J_FETCH};
      UA_RD0:   w = '{op: MO_RD_CUR,  res: RS_NONE, jmp: J_NEXT};
      UA_RD1:   w = '{op: MO_NONE,    res: RS_READ, jmp: J_FETCH};
      UA_INS0:  w = '{op: MO_RD_NBR,  res: RS_NONE, jmp: J_NEXT};
      UA_INS1:  w = '{op: MO_WR_NEW,  res: RS_NONE, jmp: J_NEXT};
      UA_INS2:  w = '{op: MO_WR_LINK, res: RS_INS,  jmp: J_FETCH};
      default:  w = '{op: MO_NONE,    res: RS_NONE, jmp: J_FETCH};
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] class_target(input req_cls_e cls);
    logic [UPC_W-1:0] t;
    unique case (cls)
      CL_READ:   t = UA_RD0;
      CL_HIDE:   t = UA_HIDE;
      CL_INSERT: t = UA_INS0;
      default:   t = UA_ERR;
    endcase
    return t;
  endfunction

  function automatic logic [ST_W-1:0] class_status(input req_cls_e cls);
    logic [ST_W-1:0] s;
    unique case (cls)
      CL_RANGE:  s = ST_RANGE;
      CL_ABSENT: s = ST_ABSENT;
      CL_FULL:   s = ST_FULL;
      default:   s = ST_OK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/idll_seq.sv]
// ----------------------------------------------------------------------------
// idll_seq
// Micro-sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_seq import idll_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire dp_stat_t   stat_i,
  output      ctrl_word_t ctrl_o,
  output      logic       in_stall_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_word_t       cw;

  assign cw         = ucode_rom(upc_q);
  assign ctrl_o     = cw;
  assign in_stall_o = (cw.jmp != J_WAIT);

  always_comb begin
    upc_d = upc_q;
    if (stat_i.go) begin
      unique case (cw.jmp)
        J_NEXT:  upc_d = upc_q + UPC_W'(1);
        J_FETCH: upc_d = UA_FETCH;
        J_WAIT:  upc_d = in_valid_i ? UA_DISP : upc_q;
        J_CLASS: upc_d = class_target(stat_i.cls);
        default: upc_d = UA_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/idll_dp.sv]
// ----------------------------------------------------------------------------
// idll_dp
// Datapath: request registers, link tables, head/count/cursor, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_dp import idll_pkg::*; #(
  parameter int unsigned MAX_IDS = MAX_IDS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_word_t        ctrl_i,
  output      dp_stat_t          stat_o,
  input  wire logic              in_valid_i,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [ID_W-1:0]   ref_id_i,
  input  wire logic              side_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [ST_W-1:0]   status_o,
  output      logic [ID_W-1:0]   id_o,
  output      logic              hidden_o,
  output      logic              last_o
);

  localparam int unsigned AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned CW = $clog2(MAX_IDS + 1);
  localparam int unsigned XW = (CW > ID_W) ? CW : ID_W;

  // link tables; entry i belongs to id i+1
  logic [CW-1:0] prev_mem [MAX_IDS];
  logic [CW-1:0] next_mem [MAX_IDS];
  logic          hid_mem  [MAX_IDS];

  logic [KIND_W-1:0] kind_q;
  logic [ID_W-1:0]   ref_q;
  logic              side_q;
  logic [CW-1:0]     cnt_q, head_q, cur_q;

  // id 1 starts with zero links; these mark its entries as written
  logic p1_q, n1_q, h1_q;

  logic [CW-1:0] prev_rd_q, next_rd_q;
  logic          hid_rd_q, z1_q;

  logic              out_valid_q;
  logic [ST_W-1:0]   status_q;
  logic [ID_W-1:0]   id_q;
  logic              hidden_q, last_q;

  logic              accept, go, emit;
  req_cls_e          cls;
  logic [XW-1:0]     ref_x, cnt_x;
  logic [CW-1:0]     cur_id, nid, ref_c, nbr;
  logic [CW-1:0]     prev_rd, next_rd;
  logic              hid_rd;
  logic [AW-1:0]     r_idx, cur_idx, n_idx, nbr_idx, rd_addr;
  logic              rd_en;

  logic              prev_we, next_we, hid_we;
  logic [AW-1:0]     prev_wa, next_wa, hid_wa;
  logic [CW-1:0]     prev_wd, next_wd;
  logic              hid_wd;

  assign accept = (ctrl_i.jmp == J_WAIT) && in_valid_i;
  assign emit   = (ctrl_i.res != RS_NONE);
  assign go     = !(emit && out_valid_q && out_stall_i);
  assign stat_o = '{cls: cls, go: go};

  assign ref_x = XW'(ref_q);
  assign cnt_x = XW'(cnt_q);

  always_comb begin
    priority if (kind_q == KIND_READ) begin
      cls = CL_READ;
    end else if ((kind_q != KIND_INS && kind_q != KIND_HIDE) || ref_x == '0
                 || ref_x > XW'(MAX_IDS)) begin
      cls = CL_RANGE;
    end else if (ref_x > cnt_x) begin
      cls = CL_ABSENT;
    end else if (kind_q == KIND_HIDE) begin
      cls = CL_HIDE;
    end else if (cnt_q == CW'(MAX_IDS)) begin
      cls = CL_FULL;
    end else begin
      cls = CL_INSERT;
    end
  end

  assign cur_id  = (cur_q == '0) ? head_q : cur_q;
  assign nid     = cnt_q + CW'(1);
  assign ref_c   = CW'(ref_q);
  assign r_idx   = AW'(ref_q - ID_W'(1));
  assign cur_idx = AW'(cur_id - CW'(1));
  assign n_idx   = AW'(cnt_q);

  assign prev_rd = (z1_q && !p1_q) ? '0 : prev_rd_q;
  assign next_rd = (z1_q && !n1_q) ? '0 : next_rd_q;
  assign hid_rd  = (z1_q && !h1_q) ? 1'b0 : hid_rd_q;
  assign nbr     = side_q ? next_rd : prev_rd;
  assign nbr_idx = AW'(nbr - CW'(1));

  assign rd_en   = (ctrl_i.op == MO_RD_CUR) || (ctrl_i.op == MO_RD_NBR);
  assign rd_addr = (ctrl_i.op == MO_RD_CUR) ? cur_idx : r_idx;

  always_comb begin
    prev_we = 1'b0;
    prev_wa = n_idx;
    prev_wd = nid;
    next_we = 1'b0;
    next_wa = n_idx;
    next_wd = nid;
    hid_we  = 1'b0;
    hid_wa  = r_idx;
    hid_wd  = 1'b0;
    unique case (ctrl_i.op)
      MO_WR_HIDE: begin
        hid_we = go;
        hid_wd = 1'b1;
      end
      MO_WR_NEW: begin
        prev_we = go;
        prev_wd = side_q ? ref_c : nbr;
        next_we = go;
        next_wd = side_q ? nbr : ref_c;
        hid_we  = go;
        hid_wa  = n_idx;
      end
      MO_WR_LINK: begin
        if (side_q) begin
          next_we = go;
          next_wa = r_idx;
          prev_we = go && (nbr != '0);
          prev_wa = nbr_idx;
        end else begin
          prev_we = go;
          prev_wa = r_idx;
          next_we = go && (nbr != '0);
          next_wa = nbr_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (hid_we) begin
      hid_mem[hid_wa] <= hid_wd;
    end
    if (rd_en) begin
      prev_rd_q <= prev_mem[rd_addr];
      next_rd_q <= next_mem[rd_addr];
      hid_rd_q  <= hid_mem[rd_addr];
    end
    if (accept) begin
      kind_q <= kind_i;
      ref_q  <= ref_id_i;
      side_q <= side_i;
    end
    if (emit && go) begin
      unique case (ctrl_i.res)
        RS_ERR: begin
          status_q <= class_status(cls);
          id_q     <= '0;
          hidden_q <= 1'b0;
          last_q   <= 1'b0;
        end
        RS_HIDE: begin
          status_q <= ST_OK;
          id_q     <= ref_q;
          hidden_q <= 1'b0;
          last_q   <= 1'b0;
        end
        RS_READ: begin
          status_q <= ST_OK;
          id_q     <= ID_W'(cur_id);
          hidden_q <= hid_rd;
          last_q   <= (next_rd == '0);
        end
        default: begin
          status_q <= ST_OK;
          id_q     <= ID_W'(nid);
          hidden_q <= 1'b0;
          last_q   <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CW'(1);
      head_q      <= CW'(1);
      cur_q       <= '0;
      p1_q        <= 1'b0;
      n1_q        <= 1'b0;
      h1_q        <= 1'b0;
      z1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_en) begin
        z1_q <= (rd_addr == '0);
      end
      if (prev_we && prev_wa == '0) begin
        p1_q <= 1'b1;
      end
      if (next_we && next_wa == '0) begin
        n1_q <= 1'b1;
      end
      if (hid_we && hid_wa == '0) begin
        h1_q <= 1'b1;
      end
      if (ctrl_i.op == MO_WR_LINK && go) begin
        cnt_q <= nid;
        if (!side_q && nbr == '0) begin
          head_q <= nid;
        end
      end
      if (ctrl_i.res == RS_READ && go) begin
        cur_q <= next_rd;
      end
      if (emit && go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign id_o        = id_q;
  assign hidden_o    = hidden_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[rtl/indexed_doubly_linked_list.sv]
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Ordered line of ids held as prev/next link tables, run by a micro-sequencer.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       request    in_valid_i / in_stall_o    kind_i, ref_id_i, side_i
// out      result     out_valid_o / out_stall_i  status_o, id_o, hidden_o, last_o
//
// One request at a time. Each passes the fetch and dispatch steps, then its
// own: error, hide, read, or insert (read the neighbour link, write the new
// entry, then relink both sides; each table has one write port).
// After reset the tables are usable at once: id 1 has its own written flags.
// A finished result waits in the output register; a new request is taken
// meanwhile, and only the step that produces the next result holds on stall.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_doubly_linked_list import idll_pkg::*; #(
  parameter int unsigned MAX_IDS = MAX_IDS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [ID_W-1:0]   ref_id_i,
  input  wire logic              side_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [ST_W-1:0]   status_o,
  output      logic [ID_W-1:0]   id_o,
  output      logic              hidden_o,
  output      logic              last_o
);

  ctrl_word_t ctrl;
  dp_stat_t   stat;

  idll_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  idll_dp #(
    .MAX_IDS (MAX_IDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .ref_id_i    (ref_id_i),
    .side_i      (side_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .id_o        (id_o),
    .hidden_o    (hidden_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

[sim/tb_indexed_doubly_linked_list.sv]
// ----------------------------------------------------------------------------
// tb_indexed_doubly_linked_list
// Checks the linked id line against a behavioural copy of its tables: directed
// edge cases, a random mix of inserts, hides, reads and malformed requests,
// then a fill to capacity, with random gaps on the request side and random
// stalls on the result side.
// ----------------------------------------------------------------------------
module tb_indexed_doubly_linked_list;
  import idll_pkg::*;

  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;
  localparam logic              SIDE_LEFT  = 1'b0;
  localparam logic              SIDE_RIGHT = 1'b1;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] id;
    logic            hidden;
    logic            last;
  } id_result_t;

  // Behavioural copy of the line; entries are indexed by id directly.
  class line_scoreboard;
    logic [ID_W-1:0] prev_link [1:MAX_IDS_DEF];
    logic [ID_W-1:0] next_link [1:MAX_IDS_DEF];
    bit              hidden_mark [1:MAX_IDS_DEF];
    int unsigned     id_count;
    int unsigned     head_id;
    int unsigned     cursor;
    id_result_t      pending_results [$];
    int unsigned     error_count;

    function new();
      for (int i = 1; i <= MAX_IDS_DEF; i++) begin
        prev_link[i]   = '0;
        next_link[i]   = '0;
        hidden_mark[i] = 1'b0;
      end
      id_count    = 1;
      head_id     = 1;
      cursor      = 0;
      error_count = 0;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] ref_id,
                               logic side);
      id_result_t  r;
      int unsigned at;
      int unsigned nid;
      int unsigned nbr;
      r = '0;
      r.status = ST_OK;
      if (kind == KIND_READ) begin
        at = (cursor == 0) ? head_id : cursor;
        if (at == 0 || at > MAX_IDS_DEF) begin
          r.last = 1'b1;
          cursor = 0;
        end else begin
          nbr      = 32'(next_link[at]);
          r.id     = at[ID_W-1:0];
          r.hidden = hidden_mark[at];
          r.last   = (nbr == 0);
          cursor   = nbr;
        end
      end else if (kind == KIND_BAD || ref_id == 0 || ref_id > MAX_IDS_DEF) begin
        r.status = ST_RANGE;
      end else if (ref_id > id_count) begin
        r.status = ST_ABSENT;
      end else if (kind == KIND_HIDE) begin
        hidden_mark[ref_id] = 1'b1;
        r.id = ref_id;
      end else if (id_count >= MAX_IDS_DEF) begin
        r.status = ST_FULL;
      end else begin
        nid = id_count + 1;
        if (side == SIDE_LEFT) begin
          nbr = 32'(prev_link[ref_id]);
          next_link[nid]    = ref_id;
          prev_link[nid]    = nbr[ID_W-1:0];
          prev_link[ref_id] = nid[ID_W-1:0];
          if (nbr != 0) next_link[nbr] = nid[ID_W-1:0];
          else head_id = nid;
        end else begin
          nbr = 32'(next_link[ref_id]);
          prev_link[nid]    = ref_id;
          next_link[nid]    = nbr[ID_W-1:0];
          next_link[ref_id] = nid[ID_W-1:0];
          if (nbr != 0) prev_link[nbr] = nid[ID_W-1:0];
        end
        id_count = nid;
        r.id = nid[ID_W-1:0];
      end
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(logic [ST_W-1:0] status, logic [ID_W-1:0] id, logic hidden,
                      logic last);
      id_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d (expected id %0d)",
                                  status, want.status, want.id));
      if (id !== want.id)
        report_mismatch($sformatf("id %0d, expected %0d", id, want.id));
      if (hidden !== want.hidden)
        report_mismatch($sformatf("hidden %0b, expected %0b (id %0d)",
                                  hidden, want.hidden, want.id));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b (id %0d)",
                                  last, want.last, want.id));
    endtask
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [KIND_W-1:0] kind_i      = KIND_INS;
  logic [ID_W-1:0]   ref_id_i    = '0;
  logic              side_i      = SIDE_LEFT;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ST_W-1:0]   status_o;
  logic [ID_W-1:0]   id_o;
  logic              hidden_o;
  logic              last_o;

  bit             quiet = 1'b0;
  line_scoreboard sb    = new();

  indexed_doubly_linked_list #(.MAX_IDS(MAX_IDS_DEF)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .ref_id_i    (ref_id_i),
    .side_i      (side_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .id_o        (id_o),
    .hidden_o    (hidden_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99, 0) < 18);
  endfunction

  function automatic logic rand_side();
    return 1'($urandom_range(1, 0));
  endfunction

  task automatic send_request(logic [KIND_W-1:0] kind, int unsigned ref_val, logic side);
    @(negedge clk_i);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    ref_id_i   <= ref_val[ID_W-1:0];
    side_i     <= side;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, ref_val[ID_W-1:0], side);
  endtask

  task automatic send_read();
    send_request(KIND_READ, $urandom_range(2047, 0), rand_side());
  endtask

  // Malformed requests: id zero, ids not yet given out, ids beyond the table,
  // and the unused kind.
  task automatic send_noise();
    int unsigned       pick;
    logic [KIND_W-1:0] kind;
    pick = $urandom_range(3, 0);
    kind = $urandom_range(1, 0) ? KIND_INS : KIND_HIDE;
    case (pick)
      0: send_request(kind, 0, rand_side());
      1: begin
        if (sb.id_count < MAX_IDS_DEF)
          send_request(kind, $urandom_range(MAX_IDS_DEF, sb.id_count + 1),
                       rand_side());
        else
          send_request(kind, MAX_IDS_DEF + 1, rand_side());
      end
      2: send_request(kind, $urandom_range(2047, MAX_IDS_DEF + 1), rand_side());
      default: send_request(KIND_BAD, $urandom_range(2047, 0), rand_side());
    endcase
  endtask

  // result side
  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= idle_now();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, id_o, hidden_o, last_o);
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned roll;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: lone head, wrap of the read cursor, error ordering, head moves
    send_request(KIND_READ, 0, SIDE_LEFT);
    send_request(KIND_READ, 2047, SIDE_RIGHT);
    send_request(KIND_HIDE, 0, SIDE_LEFT);
    send_request(KIND_HIDE, MAX_IDS_DEF + 1, SIDE_LEFT);
    send_request(KIND_INS, 2047, SIDE_RIGHT);
    send_request(KIND_INS, 2, SIDE_LEFT);
    send_request(KIND_INS, MAX_IDS_DEF, SIDE_RIGHT);
    send_request(KIND_BAD, 1, SIDE_LEFT);
    send_request(KIND_INS, 1, SIDE_LEFT);
    send_request(KIND_INS, 1, SIDE_RIGHT);
    send_request(KIND_INS, 2, SIDE_LEFT);
    send_request(KIND_READ, 0, SIDE_LEFT);
    send_request(KIND_READ, 0, SIDE_LEFT);
    // new ids right of the cursor are read in turn
    send_request(KIND_INS, 2, SIDE_RIGHT);
    send_request(KIND_HIDE, 3, SIDE_LEFT);
    send_request(KIND_HIDE, 3, SIDE_RIGHT);
    send_request(KIND_HIDE, 6, SIDE_LEFT);
    repeat (6) send_request(KIND_READ, 0, SIDE_LEFT);
    send_request(KIND_INS, 0, SIDE_RIGHT);

    for (int n = 0; n < 900; n++) begin
      quiet = (n >= 400 && n < 550);
      roll  = $urandom_range(99, 0);
      if (roll < 35)
        send_request(KIND_INS, $urandom_range(sb.id_count, 1), rand_side());
      else if (roll < 50)
        send_request(KIND_HIDE, $urandom_range(sb.id_count, 1), rand_side());
      else if (roll < 90)
        send_read();
      else
        send_noise();
    end
    quiet = 1'b0;

    // fill the table to capacity, reading along the way
    while (sb.id_count < MAX_IDS_DEF) begin
      if ($urandom_range(7, 0) == 0)
        send_read();
      else
        send_request(KIND_INS, $urandom_range(sb.id_count, 1), rand_side());
    end
    send_request(KIND_INS, MAX_IDS_DEF, SIDE_LEFT);
    send_request(KIND_INS, 1, SIDE_RIGHT);
    send_request(KIND_HIDE, MAX_IDS_DEF, SIDE_RIGHT);
    send_request(KIND_INS, MAX_IDS_DEF + 1, SIDE_LEFT);
    send_request(KIND_BAD, MAX_IDS_DEF, SIDE_RIGHT);
    for (int n = 0; n < 40; n++) begin
      roll = $urandom_range(9, 0);
      if (roll < 6) send_read();
      else if (roll < 8) send_request(KIND_HIDE, $urandom_range(MAX_IDS_DEF, 1), SIDE_LEFT);
      else send_noise();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
